[rtl/core/dbsc_pkg.sv]
// ----------------------------------------------------------------------------
// dbsc_pkg
// Shared widths, command and register codes and the configuration bundle of
// the round brush stamping canvas.
// ----------------------------------------------------------------------------
`default_nettype none

package dbsc_pkg;

    // request fields
    localparam int CMD_W  = 2;
    localparam int POS_W  = 11;
    localparam int PMAG_W = POS_W - 1;

    // configuration port
    localparam int IDX_W = 2;
    localparam int CFG_W = 9;
    localparam int DIM_W = 9;
    localparam int RAD_W = 6;
    localparam int RSQ_W = 2 * RAD_W;

    // brush scan arithmetic
    localparam int DX_W  = RAD_W + 1;
    localparam int SQ_W  = RSQ_W + 1;
    localparam int CRD_W = 12;
    localparam int MAG_W = CRD_W - 1;

    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_NONE = 8'h00;

    localparam logic [CMD_W-1:0] CMD_DOT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [RAD_W-1:0] RADIUS_RST = 6'd8;

    typedef struct packed {
        logic [DIM_W-1:0] eff_width;
        logic [DIM_W-1:0] eff_height;
        logic [RAD_W-1:0] radius;
        logic [RSQ_W-1:0] radius_sq;
        logic             wipe;
    } dbsc_cfg_t;

endpackage

`default_nettype wire

[rtl/core/dbsc_row_ram.sv]
// ----------------------------------------------------------------------------
// dbsc_row_ram
// Single-port-write, single-port-read row memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsc_row_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/dbsc_cfg.sv]
// ----------------------------------------------------------------------------
// dbsc_cfg
// Configuration registers; saturates them to the build limits and flags
// a canvas wipe when the width or height register is written.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsc_cfg #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dbsc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [dbsc_pkg::CFG_W-1:0]  cfg_data,
    output dbsc_pkg::dbsc_cfg_t         cfg
);

    import dbsc_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [RAD_W-1:0] radius_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            radius_reg <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= DIM_W'(cfg_data);
                REG_HEIGHT: height_reg <= DIM_W'(cfg_data);
                REG_RADIUS: radius_reg <= RAD_W'(cfg_data);
                default:    ;
            endcase
        end
    end

    assign radius_sat = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;

    always_comb
    begin
        cfg.eff_width  = (int'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
        cfg.eff_height = (int'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;
        cfg.radius     = radius_sat;
        cfg.radius_sq  = RSQ_W'(radius_sat) * RSQ_W'(radius_sat);
        cfg.wipe       = cfg_we && (cfg_index inside {REG_WIDTH, REG_HEIGHT});
    end

endmodule

`default_nettype wire

[rtl/core/disk_brush_stamp_canvas_top.sv]
// ----------------------------------------------------------------------------
// disk_brush_stamp_canvas_top
// One-bit canvas with a round brush: dot, clear and pixel read requests.
// ----------------------------------------------------------------------------
// Usage:
//   request channel: in_valid / in_stall with cmd, pos_x, pos_y; a request
//   is taken when in_valid is high and in_stall low. One request is worked
//   at a time; every request gives exactly one result on out_valid /
//   out_stall (is_read_result, blue, green, red, alpha, BGRA order).
//   Steps per request, r = saturated brush radius (a dot with r = 0 stamps nothing):
//     dot   : per brush row on the canvas, a row read into a register,
//             a one-pixel-per-cycle brush scan over it and a row write;
//             a brush row off the canvas is skipped
//     clear : one canvas row written per cycle, over all MAX_HEIGHT rows
//     read  : one memory read; an off-canvas read or unused code reads nothing
//   The canvas is a row memory of MAX_HEIGHT words of MAX_WIDTH bits.
//   After reset, and after a write of canvas_width or canvas_height while
//   idle or clearing, a clearing pass over every row runs with in_stall high.
//   The result register holds while out_stall is high; the next request is
//   still taken and worked, and waits at its end for the register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_brush_stamp_canvas_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dbsc_pkg::CMD_W-1:0]        cmd,
    input  logic signed [dbsc_pkg::POS_W-1:0] pos_x,
    input  logic signed [dbsc_pkg::POS_W-1:0] pos_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              is_read_result,
    output logic [dbsc_pkg::BYTE_W-1:0]       blue,
    output logic [dbsc_pkg::BYTE_W-1:0]       green,
    output logic [dbsc_pkg::BYTE_W-1:0]       red,
    output logic [dbsc_pkg::BYTE_W-1:0]       alpha,
    input  logic                              cfg_we,
    input  logic [dbsc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [dbsc_pkg::CFG_W-1:0]        cfg_data
);

    import dbsc_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [YW-1:0] ROW_LAST = YW'(MAX_HEIGHT - 1);
    localparam logic signed [DX_W-1:0]  DX_ONE  = DX_W'(1);
    localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);
    localparam logic signed [SQ_W:0]    SQ_ONE  = (SQ_W+1)'(1);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_ROW   = 9'b000000100,
        ST_LOAD  = 9'b000001000,
        ST_SCAN  = 9'b000010000,
        ST_WR    = 9'b000100000,
        ST_PEEK  = 9'b001000000,
        ST_PICK  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    dbsc_cfg_t cfg;

    state_t state_reg, state_next;
    logic [YW-1:0] clr_cnt_reg, clr_cnt_next;
    logic clr_item_reg, clr_item_next;
    logic out_valid_reg, out_valid_next;

    logic signed [CRD_W-1:0] cx_reg, cx_next;
    logic signed [CRD_W-1:0] tx_reg, tx_next;
    logic signed [CRD_W-1:0] ty_reg, ty_next;
    logic signed [DX_W-1:0]  dx_reg, dx_next;
    logic signed [DX_W-1:0]  dy_reg, dy_next;
    logic [SQ_W-1:0] dxsq_reg, dxsq_next;
    logic [SQ_W-1:0] dysq_reg, dysq_next;
    logic [SQ_W-1:0] rsq_reg, rsq_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [MAX_WIDTH-1:0] row_reg, row_next;
    logic res_read_reg, res_read_next;
    logic res_black_reg, res_black_next;
    logic out_read_reg, out_read_next;
    logic out_black_reg, out_black_next;

    logic accept;
    logic out_free;
    logic pos_on;
    logic tx_on;
    logic ty_on;
    logic in_disk;
    logic row_adv;
    logic row_last;
    logic signed [DX_W-1:0] rad_s;
    logic signed [DX_W-1:0] rad_last;
    logic signed [SQ_W:0]   dx_step;
    logic signed [SQ_W:0]   dy_step;

    logic                 mem_we;
    logic [YW-1:0]        mem_waddr;
    logic [MAX_WIDTH-1:0] mem_wdata;
    logic                 mem_re;
    logic [YW-1:0]        mem_raddr;
    logic [MAX_WIDTH-1:0] mem_rdata;

    dbsc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a row written at one edge is read no earlier than the next edge, so
    // the read-modify-write of a row needs no forwarding
    dbsc_row_ram #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (MAX_WIDTH),
        .AW    (YW)
    ) u_canvas (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE) || cfg.wipe;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign pos_on = !pos_x[POS_W-1] && !pos_y[POS_W-1]
                    && (pos_x[PMAG_W-1:0] < PMAG_W'(cfg.eff_width))
                    && (pos_y[PMAG_W-1:0] < PMAG_W'(cfg.eff_height));
    assign tx_on  = !tx_reg[CRD_W-1] && (tx_reg[MAG_W-1:0] < MAG_W'(cfg.eff_width));
    assign ty_on  = !ty_reg[CRD_W-1] && (ty_reg[MAG_W-1:0] < MAG_W'(cfg.eff_height));

    assign rad_s    = $signed({1'b0, rad_reg});
    assign rad_last = rad_s - DX_ONE;
    assign row_last = (dy_reg == rad_last);
    assign in_disk  = ((SQ_W+1)'(dxsq_reg) + (SQ_W+1)'(dysq_reg)) < (SQ_W+1)'(rsq_reg);

    // (d+1)^2 = d^2 + 2d + 1
    assign dx_step = $signed({1'b0, dxsq_reg}) + ((SQ_W+1)'(dx_reg) <<< 1) + SQ_ONE;
    assign dy_step = $signed({1'b0, dysq_reg}) + ((SQ_W+1)'(dy_reg) <<< 1) + SQ_ONE;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_item_next  = clr_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_read_next  = out_read_reg;
        out_black_next = out_black_reg;
        cx_next        = cx_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dxsq_next      = dxsq_reg;
        dysq_next      = dysq_reg;
        rsq_next       = rsq_reg;
        rad_next       = rad_reg;
        row_next       = row_reg;
        res_read_next  = res_read_reg;
        res_black_next = res_black_reg;
        row_adv        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ty_reg[YW-1:0];
        mem_wdata      = row_reg;
        mem_re         = 1'b0;
        mem_raddr      = ty_reg[YW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == ROW_LAST)
                begin
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + YW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_read_next  = 1'b0;
                    res_black_next = 1'b0;
                    cx_next        = CRD_W'(pos_x);
                    rad_next       = cfg.radius;
                    rsq_next       = SQ_W'(cfg.radius_sq);
                    dysq_next      = SQ_W'(cfg.radius_sq);
                    dy_next        = -$signed({1'b0, cfg.radius});
                    case (cmd)
                        CMD_DOT:
                        begin
                            ty_next    = CRD_W'(pos_y) - CRD_W'($signed({1'b0, cfg.radius}));
                            state_next = (cfg.radius == '0) ? ST_DONE : ST_ROW;
                        end
                        CMD_CLEAR:
                        begin
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            ty_next    = CRD_W'(pos_y);
                            state_next = pos_on ? ST_PEEK : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                if (ty_on)
                begin
                    mem_re     = 1'b1;
                    dx_next    = -rad_s;
                    tx_next    = cx_reg - CRD_W'(rad_s);
                    dxsq_next  = rsq_reg;
                    state_next = ST_LOAD;
                end
                else
                begin
                    row_adv = 1'b1;
                end
            end
            ST_LOAD:
            begin
                row_next   = mem_rdata;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (in_disk && tx_on)
                begin
                    row_next[tx_reg[XW-1:0]] = 1'b1;
                end
                dx_next   = dx_reg + DX_ONE;
                tx_next   = tx_reg + CRD_ONE;
                dxsq_next = dx_step[SQ_W-1:0];
                if (dx_reg == rad_last)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                mem_we  = 1'b1;
                row_adv = 1'b1;
            end
            ST_PEEK:
            begin
                mem_re     = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                res_read_next  = 1'b1;
                res_black_next = mem_rdata[cx_reg[XW-1:0]];
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_read_next  = res_read_reg;
                    out_black_next = res_black_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (row_adv)
        begin
            if (row_last)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                dy_next    = dy_reg + DX_ONE;
                ty_next    = ty_reg + CRD_ONE;
                dysq_next  = dy_step[SQ_W-1:0];
                state_next = ST_ROW;
            end
        end

        // resize restarts the clearing pass
        if (cfg.wipe && (state_reg inside {ST_IDLE, ST_CLEAR}))
        begin
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg        <= cx_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        dxsq_reg      <= dxsq_next;
        dysq_reg      <= dysq_next;
        rsq_reg       <= rsq_next;
        rad_reg       <= rad_next;
        row_reg       <= row_next;
        res_read_reg  <= res_read_next;
        res_black_reg <= res_black_next;
        out_read_reg  <= out_read_next;
        out_black_reg <= out_black_next;
    end

    assign out_valid      = out_valid_reg;
    assign is_read_result = out_read_reg;
    assign blue           = (out_read_reg && !out_black_reg) ? BYTE_FULL : BYTE_NONE;
    assign green          = (out_read_reg && !out_black_reg) ? BYTE_FULL : BYTE_NONE;
    assign red            = (out_read_reg && !out_black_reg) ? BYTE_FULL : BYTE_NONE;
    assign alpha          = out_read_reg ? BYTE_FULL : BYTE_NONE;

`ifndef ASSERT_OFF
    a_wr_on_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> !ty_reg[CRD_W-1]
                               && (ty_reg[MAG_W-1:0] < MAG_W'(cfg.eff_height)))
        else $error("row write outside the canvas height");

    a_scan_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (dx_reg <= rad_last) && (dx_reg >= -rad_s))
        else $error("brush column offset out of span");

    a_pick_after_peek: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PICK |-> $past(state_reg == ST_PEEK))
        else $error("pixel pick without a row read");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");
`endif

endmodule

`default_nettype wire
